[design/tcce_pkg.sv]
package tcce_pkg;

	// Field widths fixed by the console command format.
	localparam int COL_W   = 7;
	localparam int ROW_W   = 5;
	localparam int GLYPH_W = 8;
	localparam int KIND_W  = 2;
	localparam int X_W     = 10;
	localparam int Y_W     = 9;
	localparam int RGB_W   = 24;
	localparam int IDX_W   = 4;

	// Control codes that move the cursor.
	localparam logic [GLYPH_W-1:0] CH_BS    = 8'h08;
	localparam logic [GLYPH_W-1:0] CH_TAB   = 8'h09;
	localparam logic [GLYPH_W-1:0] CH_NL    = 8'h0A;
	localparam logic [GLYPH_W-1:0] CH_CR    = 8'h0D;
	localparam logic [GLYPH_W-1:0] CH_SPACE = 8'h20;

	// Request modes.
	localparam logic MODE_PUT   = 1'b0;
	localparam logic MODE_CLEAR = 1'b1;

	// Register indexes on the configuration port.
	localparam logic [1:0] REG_ENABLED = 2'd0;
	localparam logic [1:0] REG_FG      = 2'd1;
	localparam logic [1:0] REG_BG      = 2'd2;

	localparam logic [IDX_W-1:0] FG_RESET = 4'd7;
	localparam logic [IDX_W-1:0] BG_RESET = 4'd0;

	// Standard 16-color text palette.
	localparam logic [RGB_W-1:0] PALETTE [16] = '{
		24'h000000, 24'h0000AA, 24'h00AA00, 24'h00AAAA,
		24'hAA0000, 24'hAA00AA, 24'hAA5500, 24'hAAAAAA,
		24'h555555, 24'h5555FF, 24'h55FF55, 24'h55FFFF,
		24'hFF5555, 24'hFF55FF, 24'hFFFF55, 24'hFFFFFF
	};

	typedef enum logic [KIND_W-1:0] {
		KIND_DRAW   = 2'd0,
		KIND_SCROLL = 2'd1,
		KIND_FILL   = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		CLS_PRINT,
		CLS_NL,
		CLS_CR,
		CLS_TAB,
		CLS_BS
	} char_class_t;

	typedef enum logic [1:0] {
		COL_HOLD,
		COL_INC,
		COL_DEC,
		COL_ZERO
	} col_op_t;

	typedef enum logic [1:0] {
		ROW_HOLD,
		ROW_INC,
		ROW_ZERO
	} row_op_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic    load;
		logic    emit;
		kind_t   kind;
		logic    space;
		logic    last;
		col_op_t col_op;
		row_op_t row_op;
	} ctrl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic        mode;
		char_class_t cls;
		logic        col_zero;
		logic        col_at_end;
		logic        col_wrap;
		logic        tab_end;
		logic        row_last;
		logic        out_free;
	} ctrl_stat_t;

endpackage

[design/tcce_ifs.sv]
interface tcce_in_if import tcce_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               mode;
	logic [GLYPH_W-1:0] glyph;

	modport source (output valid, output mode, output glyph, input ready);
	modport sink (input valid, input mode, input glyph, output ready);
endinterface

interface tcce_out_if import tcce_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [KIND_W-1:0]  kind;
	logic [X_W-1:0]     pixel_x;
	logic [Y_W-1:0]     pixel_y;
	logic [GLYPH_W-1:0] cell_char;
	logic [RGB_W-1:0]   fg_rgb;
	logic [RGB_W-1:0]   bg_rgb;
	logic               last;

	modport source (output valid, output kind, output pixel_x, output pixel_y,
		output cell_char, output fg_rgb, output bg_rgb, output last, input ready);
	modport sink (input valid, input kind, input pixel_x, input pixel_y,
		input cell_char, input fg_rgb, input bg_rgb, input last, output ready);
endinterface

[design/tcce_ctrl.sv]
module tcce_ctrl import tcce_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       enabled,
	input  ctrl_stat_t stat,
	output ctrl_cmd_t  cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_RUN,
		S_TAB,
		S_BSDRAW,
		S_PRINT,
		S_SCROLL
	} state_t;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d    = state_q;
		cmd.load   = 1'b0;
		cmd.emit   = 1'b0;
		cmd.kind   = KIND_DRAW;
		cmd.space  = 1'b0;
		cmd.last   = 1'b0;
		cmd.col_op = COL_HOLD;
		cmd.row_op = ROW_HOLD;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_RUN;
				end
			end
			S_RUN: begin
				if (stat.mode == MODE_CLEAR) begin
					if (!enabled) begin
						cmd.col_op = COL_ZERO;
						cmd.row_op = ROW_ZERO;
						state_d    = S_IDLE;
					end else if (stat.out_free) begin
						cmd.emit   = 1'b1;
						cmd.kind   = KIND_FILL;
						cmd.last   = 1'b1;
						cmd.col_op = COL_ZERO;
						cmd.row_op = ROW_ZERO;
						state_d    = S_IDLE;
					end
				end else if (!enabled) begin
					state_d = S_IDLE;
				end else begin
					unique case (stat.cls)
						CLS_NL: begin
							cmd.col_op = COL_ZERO;
							if (stat.row_last) begin
								state_d = S_SCROLL;
							end else begin
								cmd.row_op = ROW_INC;
								state_d    = S_IDLE;
							end
						end
						CLS_CR: begin
							cmd.col_op = COL_ZERO;
							state_d    = S_IDLE;
						end
						CLS_BS: begin
							if (stat.col_zero) begin
								state_d = S_IDLE;
							end else begin
								cmd.col_op = COL_DEC;
								state_d    = S_BSDRAW;
							end
						end
						CLS_TAB: begin
							state_d = stat.col_at_end ? S_IDLE : S_TAB;
						end
						CLS_PRINT: begin
							state_d = S_PRINT;
						end
						default: begin
							state_d = S_IDLE;
						end
					endcase
				end
			end
			S_TAB: begin
				if (stat.out_free) begin
					cmd.emit   = 1'b1;
					cmd.space  = 1'b1;
					cmd.last   = stat.tab_end;
					cmd.col_op = COL_INC;
					if (stat.tab_end) begin
						state_d = S_IDLE;
					end
				end
			end
			S_BSDRAW: begin
				if (stat.out_free) begin
					cmd.emit  = 1'b1;
					cmd.space = 1'b1;
					cmd.last  = 1'b1;
					state_d   = S_IDLE;
				end
			end
			S_PRINT: begin
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					cmd.last = !(stat.col_wrap && stat.row_last);
					if (stat.col_wrap) begin
						cmd.col_op = COL_ZERO;
						if (stat.row_last) begin
							state_d = S_SCROLL;
						end else begin
							cmd.row_op = ROW_INC;
							state_d    = S_IDLE;
						end
					end else begin
						cmd.col_op = COL_INC;
						state_d    = S_IDLE;
					end
				end
			end
			S_SCROLL: begin
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					cmd.kind = KIND_SCROLL;
					cmd.last = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// A result is only written into the output register when it has room.
	a_emit_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> stat.out_free)
		else $error("result written while output register occupied");

	// An accepted request always moves on to decoding in S_RUN.
	a_accept_runs: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == S_RUN))
		else $error("accepted request not decoded");

	// A scroll is only ever requested for a cursor sitting on the bottom row.
	a_scroll_row: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCROLL) |-> stat.row_last)
		else $error("scroll pending with cursor above the bottom row");

endmodule

[design/tcce_dp.sv]
module tcce_dp import tcce_pkg::*; #(
	parameter int COLUMNS     = 80,
	parameter int ROWS        = 25,
	parameter int TAB_STOP    = 8,
	parameter int CELL_WIDTH  = 8,
	parameter int CELL_HEIGHT = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_mode,
	input  logic [GLYPH_W-1:0] in_glyph,
	input  logic [IDX_W-1:0]   fg_index,
	input  logic [IDX_W-1:0]   bg_index,
	input  ctrl_cmd_t          cmd,
	output ctrl_stat_t         stat,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [KIND_W-1:0]  out_kind,
	output logic [X_W-1:0]     out_pixel_x,
	output logic [Y_W-1:0]     out_pixel_y,
	output logic [GLYPH_W-1:0] out_cell_char,
	output logic [RGB_W-1:0]   out_fg_rgb,
	output logic [RGB_W-1:0]   out_bg_rgb,
	output logic               out_last
);

	localparam int PH_W = $clog2(TAB_STOP);
	localparam logic [PH_W-1:0]  PH_LAST  = PH_W'(TAB_STOP - 1);
	localparam logic [COL_W-1:0] COL_END  = COL_W'(COLUMNS);
	localparam logic [COL_W-1:0] COL_LAST = COL_W'(COLUMNS - 1);
	localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(ROWS - 1);

	logic [COL_W-1:0]   col_q;
	logic [ROW_W-1:0]   row_q;
	logic [PH_W-1:0]    phase_q;
	logic               mode_q;
	logic [GLYPH_W-1:0] glyph_q;

	kind_t              kind_q;
	logic               valid_q;
	logic [X_W-1:0]     x_q;
	logic [Y_W-1:0]     y_q;
	logic [GLYPH_W-1:0] char_q;
	logic [RGB_W-1:0]   fg_q;
	logic [RGB_W-1:0]   bg_q;
	logic               last_q;

	logic [31:0]        x_full;
	logic [31:0]        y_full;

	// Cursor, with phase_q tracking the column modulo the tab stop.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			row_q   <= '0;
			phase_q <= '0;
		end else begin
			unique case (cmd.col_op)
				COL_INC: begin
					col_q   <= col_q + COL_W'(1);
					phase_q <= (phase_q == PH_LAST) ? '0 : phase_q + PH_W'(1);
				end
				COL_DEC: begin
					col_q   <= col_q - COL_W'(1);
					phase_q <= (phase_q == '0) ? PH_LAST : phase_q - PH_W'(1);
				end
				COL_ZERO: begin
					col_q   <= '0;
					phase_q <= '0;
				end
				default: begin
				end
			endcase
			unique case (cmd.row_op)
				ROW_INC:  row_q <= row_q + ROW_W'(1);
				ROW_ZERO: row_q <= '0;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q  <= in_mode;
			glyph_q <= in_glyph;
		end
	end

	always_comb begin
		unique case (glyph_q)
			CH_NL:   stat.cls = CLS_NL;
			CH_CR:   stat.cls = CLS_CR;
			CH_TAB:  stat.cls = CLS_TAB;
			CH_BS:   stat.cls = CLS_BS;
			default: stat.cls = CLS_PRINT;
		endcase
	end

	assign stat.mode       = mode_q;
	assign stat.col_zero   = (col_q == '0);
	assign stat.col_at_end = (col_q == COL_END);
	assign stat.col_wrap   = (col_q >= COL_LAST);
	assign stat.tab_end    = (phase_q == PH_LAST) || (col_q >= COL_LAST);
	assign stat.row_last   = (row_q == ROW_LAST);
	assign stat.out_free   = !valid_q || out_ready;

	assign x_full = 32'(col_q) * 32'(CELL_WIDTH);
	assign y_full = 32'(row_q) * 32'(CELL_HEIGHT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.emit) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			kind_q <= cmd.kind;
			last_q <= cmd.last;
			unique case (cmd.kind)
				KIND_DRAW: begin
					x_q    <= x_full[X_W-1:0];
					y_q    <= y_full[Y_W-1:0];
					char_q <= cmd.space ? CH_SPACE : glyph_q;
					fg_q   <= PALETTE[fg_index];
					bg_q   <= PALETTE[bg_index];
				end
				KIND_FILL: begin
					x_q    <= '0;
					y_q    <= '0;
					char_q <= '0;
					fg_q   <= '0;
					bg_q   <= PALETTE[bg_index];
				end
				default: begin
					x_q    <= '0;
					y_q    <= '0;
					char_q <= '0;
					fg_q   <= '0;
					bg_q   <= '0;
				end
			endcase
		end
	end

	assign out_valid     = valid_q;
	assign out_kind      = kind_q;
	assign out_pixel_x   = x_q;
	assign out_pixel_y   = y_q;
	assign out_cell_char = char_q;
	assign out_fg_rgb    = fg_q;
	assign out_bg_rgb    = bg_q;
	assign out_last      = last_q;

	// The column may sit one past the last cell only after a tab.
	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		col_q <= COL_END)
		else $error("cursor column beyond row end");

	a_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		row_q <= ROW_LAST)
		else $error("cursor row beyond bottom row");

	// The tab phase follows the column back to zero on every home or return.
	a_phase_home: assert property (@(posedge clk) disable iff (!arst_n)
		(col_q == '0) |-> (phase_q == '0))
		else $error("tab phase out of step with column");

endmodule

[design/text_console_cursor_engine_core.sv]
// Channel   Dir  Handshake       Payload
// in_ch     in   valid / ready   mode, glyph
// out_ch    out  valid / ready   kind, pixel_x, pixel_y, cell_char, fg_rgb, bg_rgb, last
// apb       in   psel / penable  paddr, pwdata, prdata (pready tied high)
//
// A request is accepted in the idle state and decoded in S_RUN, where a fill is also
// written; each other result is written from a later state of the sequencer in tcce_ctrl:
// S_TAB for the blanks of a tab, S_BSDRAW, S_PRINT or S_SCROLL; a clear or a silent code ends in S_RUN.
// arst_n clears the cursor to home, the controller to idle, the output register to
// empty and the registers to disabled, light gray on black.
// A result waiting in the output register stalls only the next result; a new request
// is taken as soon as the previous one has written its last result.
module text_console_cursor_engine_core import tcce_pkg::*; #(
	parameter int COLUMNS     = 80,
	parameter int ROWS        = 25,
	parameter int TAB_STOP    = 8,
	parameter int CELL_WIDTH  = 8,
	parameter int CELL_HEIGHT = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	tcce_in_if.sink     in_ch,
	tcce_out_if.source  out_ch
);

	// Configuration registers. They are to be written only while the engine is idle,
	// so the datapath reads them directly; the block itself does not enforce this.
	logic             enabled_q;
	logic [IDX_W-1:0] fg_index_q;
	logic [IDX_W-1:0] bg_index_q;
	logic [1:0]       reg_index;
	logic             cfg_write;

	ctrl_cmd_t  cmd;
	ctrl_stat_t stat;

	assign pready    = 1'b1;
	assign reg_index = paddr[3:2];
	assign cfg_write = psel && penable && pwrite && pready;

	// Writes to an address past the last register are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enabled_q  <= 1'b0;
			fg_index_q <= FG_RESET;
			bg_index_q <= BG_RESET;
		end else if (cfg_write) begin
			unique case (reg_index)
				REG_ENABLED: enabled_q  <= pwdata[0];
				REG_FG:      fg_index_q <= pwdata[IDX_W-1:0];
				REG_BG:      bg_index_q <= pwdata[IDX_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (reg_index)
			REG_ENABLED: prdata = {31'd0, enabled_q};
			REG_FG:      prdata = {28'd0, fg_index_q};
			REG_BG:      prdata = {28'd0, bg_index_q};
			default:     prdata = '0;
		endcase
	end

	// The controller decides what each decoded request does and paces results
	// against the output register; the datapath holds the cursor and formats the
	// framebuffer command.
	tcce_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ch.ready),
		.enabled  (enabled_q),
		.stat     (stat),
		.cmd      (cmd)
	);

	tcce_dp #(
		.COLUMNS     (COLUMNS),
		.ROWS        (ROWS),
		.TAB_STOP    (TAB_STOP),
		.CELL_WIDTH  (CELL_WIDTH),
		.CELL_HEIGHT (CELL_HEIGHT)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_mode       (in_ch.mode),
		.in_glyph      (in_ch.glyph),
		.fg_index      (fg_index_q),
		.bg_index      (bg_index_q),
		.cmd           (cmd),
		.stat          (stat),
		.out_valid     (out_ch.valid),
		.out_ready     (out_ch.ready),
		.out_kind      (out_ch.kind),
		.out_pixel_x   (out_ch.pixel_x),
		.out_pixel_y   (out_ch.pixel_y),
		.out_cell_char (out_ch.cell_char),
		.out_fg_rgb    (out_ch.fg_rgb),
		.out_bg_rgb    (out_ch.bg_rgb),
		.out_last      (out_ch.last)
	);

endmodule

[bench/text_console_cursor_engine_core_test.sv]
`timescale 1ns / 1ps

module text_console_cursor_engine_core_test;
	import tcce_pkg::*;

	// Geometry of the console under test. These match the defaults of the core and
	// are passed to the instance so that the prediction below uses the same values.
	localparam int COLUMNS     = 80;
	localparam int ROWS        = 25;
	localparam int TAB_STOP    = 8;
	localparam int CELL_WIDTH  = 8;
	localparam int CELL_HEIGHT = 16;

	// A tab is the slowest request: it is accepted, decoded and then draws its blanks one
	// by one. SETTLE_CYCLES is let pass before a register write, so that a control code
	// which produces no command has surely finished as well.
	localparam int SETTLE_CYCLES = 2 * (TAB_STOP + 2);

	// Random part: three phases of 140 counted requests each, sent in
	// blocks that each start with a fresh register setting.
	localparam int PHASE_REQUESTS = 140;
	localparam int BLOCK_REQUESTS = 35;
	localparam int IGNORED_BLOCK  = 6;
	localparam int REPORT_LIMIT   = 10;
	localparam int TIMEOUT_NS     = 2_000_000;

	// One framebuffer command as it leaves the core.
	typedef struct {
		kind_t              kind;
		logic [X_W-1:0]     pixel_x;
		logic [Y_W-1:0]     pixel_y;
		logic [GLYPH_W-1:0] cell_char;
		logic [RGB_W-1:0]   fg_rgb;
		logic [RGB_W-1:0]   bg_rgb;
		logic               last;
	} fb_cmd_t;

	// One row of the directed table: either a register write or a request that is
	// sent a number of times. fixed_n below zero means the commands come from the
	// cursor prediction; zero or one means the row carries its own answer.
	typedef enum {ACT_REQUEST, ACT_WRITE} plan_act_t;

	typedef struct {
		plan_act_t          act;
		logic [1:0]         reg_idx;
		logic [31:0]        value;
		logic               mode;
		logic [GLYPH_W-1:0] glyph;
		int                 repeats;
		int                 fixed_n;
		fb_cmd_t            fixed_cmd;
	} plan_row_t;

	logic        clk     = 1'b0;
	logic        arst_n  = 1'b0;
	logic        psel    = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite  = 1'b0;
	logic [3:0]  paddr   = '0;
	logic [31:0] pwdata  = '0;
	logic [31:0] prdata;
	logic        pready;

	tcce_in_if  in_ch ();
	tcce_out_if out_ch ();

	text_console_cursor_engine_core #(
		.COLUMNS    (COLUMNS),
		.ROWS       (ROWS),
		.TAB_STOP   (TAB_STOP),
		.CELL_WIDTH (CELL_WIDTH),
		.CELL_HEIGHT(CELL_HEIGHT)
	) i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	always #2 clk = ~clk;

	// Our own copy of the cursor and of the registers, at their reset values.
	logic [COL_W-1:0] cur_col = '0;
	logic [ROW_W-1:0] cur_row = '0;
	logic             en_reg  = 1'b0;
	logic [IDX_W-1:0] fg_reg  = FG_RESET;
	logic [IDX_W-1:0] bg_reg  = BG_RESET;

	// Commands produced by the latest request, and commands still owed by the core.
	fb_cmd_t step_cmds[$];
	fb_cmd_t pending_cmds[$];
	plan_row_t plan[$];

	int failures       = 0;
	int send_gap_pct   = 7;
	int recv_stall_pct = 68;

	function automatic fb_cmd_t make_cmd(kind_t kind, int x, int y, logic [GLYPH_W-1:0] ch,
			logic [RGB_W-1:0] fg, logic [RGB_W-1:0] bg);
		fb_cmd_t c;
		c.kind      = kind;
		c.pixel_x   = x[X_W-1:0];
		c.pixel_y   = y[Y_W-1:0];
		c.cell_char = ch;
		c.fg_rgb    = fg;
		c.bg_rgb    = bg;
		c.last      = 1'b0;
		return c;
	endfunction

	// A glyph cell at a text position, in the colors currently selected. The pixel
	// position is cut to the port width, as the core does.
	function automatic fb_cmd_t draw_cmd(int col, int row, logic [GLYPH_W-1:0] ch);
		return make_cmd(KIND_DRAW, col * CELL_WIDTH, row * CELL_HEIGHT, ch,
			PALETTE[fg_reg], PALETTE[bg_reg]);
	endfunction

	function automatic string cmd_text(fb_cmd_t c);
		return $sformatf("kind %0d x %0d y %0d char %02h fg %06h bg %06h last %0b",
			c.kind, c.pixel_x, c.pixel_y, c.cell_char, c.fg_rgb, c.bg_rgb, c.last);
	endfunction

	function automatic plan_row_t plan_req(logic mode, logic [GLYPH_W-1:0] glyph, int repeats,
			int fixed_n, fb_cmd_t cmd);
		plan_row_t r;
		r.act       = ACT_REQUEST;
		r.reg_idx   = REG_ENABLED;
		r.value     = '0;
		r.mode      = mode;
		r.glyph     = glyph;
		r.repeats   = repeats;
		r.fixed_n   = fixed_n;
		r.fixed_cmd = cmd;
		r.fixed_cmd.last = 1'b1;
		return r;
	endfunction

	function automatic plan_row_t plan_wr(logic [1:0] idx, logic [31:0] value);
		plan_row_t r;
		r = plan_req(MODE_PUT, '0, 0, 0, make_cmd(KIND_DRAW, 0, 0, '0, '0, '0));
		r.act     = ACT_WRITE;
		r.reg_idx = idx;
		r.value   = value;
		return r;
	endfunction

	task automatic flag_failure(string msg);
		failures++;
		if (failures <= REPORT_LIMIT) begin
			$display("[%0t] %s", $realtime, msg);
		end
	endtask

	// Cursor prediction for one accepted request. It leaves the commands of the
	// request in step_cmds and moves our copy of the cursor.
	task automatic console_step(logic mode, logic [GLYPH_W-1:0] glyph);
		int col;
		int row;
		int stop_col;
		step_cmds.delete();
		col = int'(cur_col);
		row = int'(cur_row);
		if (mode == MODE_CLEAR) begin
			// Clear homes the cursor whatever the enable says; only the fill needs it.
			col = 0;
			row = 0;
			if (en_reg) begin
				step_cmds.push_back(make_cmd(KIND_FILL, 0, 0, '0, '0, PALETTE[bg_reg]));
			end
		end else if (en_reg) begin
			case (glyph)
				CH_NL: begin
					col = 0;
					row++;
				end
				CH_CR: begin
					col = 0;
				end
				CH_TAB: begin
					// Blanks up to the next stop, never past the row end. A tab that
					// starts at column COLUMNS draws nothing.
					stop_col = (col / TAB_STOP + 1) * TAB_STOP;
					while (col < stop_col && col < COLUMNS) begin
						step_cmds.push_back(draw_cmd(col, row, CH_SPACE));
						col++;
					end
				end
				CH_BS: begin
					if (col > 0) begin
						col--;
						step_cmds.push_back(draw_cmd(col, row, CH_SPACE));
					end
				end
				default: begin
					// Every other code, zero included, is drawn and then advances.
					step_cmds.push_back(draw_cmd(col, row, glyph));
					col++;
					if (col >= COLUMNS) begin
						col = 0;
						row++;
					end
				end
			endcase
			if (row >= ROWS) begin
				step_cmds.push_back(make_cmd(KIND_SCROLL, 0, 0, '0, '0, '0));
				row = ROWS - 1;
			end
		end
		if (step_cmds.size() > 0) begin
			step_cmds[step_cmds.size() - 1].last = 1'b1;
		end
		cur_col = COL_W'(col);
		cur_row = ROW_W'(row);
	endtask

	// Sends one request, with random idle cycles in front of it as the phase asks,
	// and books the commands it owes once the core has taken it.
	task automatic send_request(logic mode, logic [GLYPH_W-1:0] glyph, int fixed_n,
			fb_cmd_t fixed_cmd);
		while ($urandom_range(0, 99) < send_gap_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.mode  <= mode;
		in_ch.glyph <= glyph;
		do @(posedge clk); while (in_ch.ready !== 1'b1);
		console_step(mode, glyph);
		if (fixed_n < 0) begin
			foreach (step_cmds[i]) pending_cmds.push_back(step_cmds[i]);
		end else if (fixed_n == 1) begin
			pending_cmds.push_back(fixed_cmd);
		end
	endtask

	// Holds the request side idle until every owed command has come out, then lets
	// settle_cycles more pass. It always waits on a clock edge first, so a request
	// that follows never drives valid twice in one time step.
	task automatic wait_drained(int settle_cycles);
		in_ch.valid <= 1'b0;
		do @(posedge clk); while (pending_cmds.size() != 0);
		repeat (settle_cycles) @(posedge clk);
	endtask

	// Register write on the configuration port, followed by a read of the same
	// register. psel stays high from the write's access cycle into the read's setup
	// cycle, and a bus idle cycle closes the transfer.
	task automatic write_register(logic [1:0] idx, logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		if (prdata !== value) begin
			flag_failure($sformatf("register %0d reads %08h, expected %08h", idx, prdata, value));
		end
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		case (idx)
			REG_ENABLED: en_reg = value[0];
			REG_FG:      fg_reg = value[IDX_W-1:0];
			REG_BG:      bg_reg = value[IDX_W-1:0];
			default:     ;
		endcase
	endtask

	// Random request mix. Newlines are common and clears rare, so that the cursor
	// regularly reaches the bottom row and the scroll path gets exercised.
	function automatic void pick_request(output logic mode, output logic [GLYPH_W-1:0] glyph);
		int roll;
		roll  = $urandom_range(0, 199);
		mode  = MODE_PUT;
		glyph = GLYPH_W'($urandom_range(0, 255));
		if (roll == 0) begin
			mode = MODE_CLEAR;
		end else if (roll < 50) begin
			glyph = CH_NL;
		end else if (roll < 66) begin
			glyph = CH_TAB;
		end else if (roll < 82) begin
			glyph = CH_BS;
		end else if (roll < 90) begin
			glyph = CH_CR;
		end else if (roll < 96) begin
			// Fully random item: both fields free, the mode mostly put.
			mode = ($urandom_range(0, 15) == 0) ? MODE_CLEAR : MODE_PUT;
		end
	endfunction

	// Command side: every accepted command is compared with the oldest one owed.
	// ready is redrawn at each edge, so stalls land on any cycle of the core's work.
	initial begin
		fb_cmd_t got;
		fb_cmd_t want;
		out_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
				got.kind      = kind_t'(out_ch.kind);
				got.pixel_x   = out_ch.pixel_x;
				got.pixel_y   = out_ch.pixel_y;
				got.cell_char = out_ch.cell_char;
				got.fg_rgb    = out_ch.fg_rgb;
				got.bg_rgb    = out_ch.bg_rgb;
				got.last      = out_ch.last;
				if (pending_cmds.size() == 0) begin
					flag_failure({"command with none owed: ", cmd_text(got)});
				end else begin
					want = pending_cmds.pop_front();
					if (got.kind !== want.kind || got.pixel_x !== want.pixel_x ||
							got.pixel_y !== want.pixel_y || got.cell_char !== want.cell_char ||
							got.fg_rgb !== want.fg_rgb || got.bg_rgb !== want.bg_rgb ||
							got.last !== want.last) begin
						flag_failure({"command mismatch: expected ", cmd_text(want),
							", got ", cmd_text(got)});
					end
				end
			end
			out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	// Stimulus: reset, the directed table, then three phases of random requests.
	initial begin
		int counted;
		int block_len;
		logic rq_mode;
		logic [GLYPH_W-1:0] rq_glyph;
		fb_cmd_t no_cmd;

		in_ch.valid <= 1'b0;
		in_ch.mode  <= MODE_PUT;
		in_ch.glyph <= '0;
		no_cmd = make_cmd(KIND_DRAW, 0, 0, '0, '0, '0);

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Right after reset the console is disabled: a character and a clear give
		// nothing, though the clear still homes the cursor.
		plan.push_back(plan_req(MODE_PUT, 8'h41, 1, 0, no_cmd));
		plan.push_back(plan_req(MODE_CLEAR, 8'hFF, 1, 0, no_cmd));
		plan.push_back(plan_wr(REG_ENABLED, 32'd1));
		// Reset colors are light gray on black; codes zero and 0xFF are printable.
		plan.push_back(plan_req(MODE_PUT, 8'h41, 1, 1,
			make_cmd(KIND_DRAW, 0, 0, 8'h41, 24'hAAAAAA, 24'h000000)));
		plan.push_back(plan_req(MODE_PUT, 8'h00, 1, 1,
			make_cmd(KIND_DRAW, 8, 0, 8'h00, 24'hAAAAAA, 24'h000000)));
		plan.push_back(plan_req(MODE_PUT, 8'hFF, 1, 1,
			make_cmd(KIND_DRAW, 16, 0, 8'hFF, 24'hAAAAAA, 24'h000000)));
		plan.push_back(plan_req(MODE_PUT, CH_BS, 1, -1, no_cmd));
		// Carriage return is silent, and a backspace at column zero does nothing.
		plan.push_back(plan_req(MODE_PUT, CH_CR, 1, 0, no_cmd));
		plan.push_back(plan_req(MODE_PUT, CH_BS, 1, 0, no_cmd));
		plan.push_back(plan_wr(REG_FG, 32'd0));
		plan.push_back(plan_wr(REG_BG, 32'd15));
		plan.push_back(plan_req(MODE_PUT, CH_NL, 1, 0, no_cmd));
		// Ten tabs walk the cursor to column COLUMNS. A tab there draws nothing, and
		// a character there draws past the last column and then wraps.
		plan.push_back(plan_req(MODE_PUT, CH_TAB, 10, -1, no_cmd));
		plan.push_back(plan_req(MODE_PUT, CH_TAB, 1, 0, no_cmd));
		plan.push_back(plan_req(MODE_PUT, 8'h7E, 1, 1,
			make_cmd(KIND_DRAW, 640, 16, 8'h7E, 24'h000000, 24'hFFFFFF)));
		plan.push_back(plan_req(MODE_PUT, CH_BS, 1, 0, no_cmd));
		plan.push_back(plan_wr(REG_FG, 32'd15));
		plan.push_back(plan_wr(REG_BG, 32'd0));
		// An enabled clear fills with the background color.
		plan.push_back(plan_req(MODE_CLEAR, 8'h00, 1, 1,
			make_cmd(KIND_FILL, 0, 0, 8'h00, 24'h000000, 24'h000000)));
		plan.push_back(plan_req(MODE_PUT, 8'h80, 1, -1, no_cmd));
		plan.push_back(plan_wr(REG_ENABLED, 32'd0));
		plan.push_back(plan_req(MODE_PUT, 8'h5A, 1, 0, no_cmd));
		plan.push_back(plan_req(MODE_CLEAR, 8'h5A, 1, 0, no_cmd));

		foreach (plan[i]) begin
			if (plan[i].act == ACT_WRITE) begin
				wait_drained(SETTLE_CYCLES);
				write_register(plan[i].reg_idx, plan[i].value);
			end else begin
				for (int k = 0; k < plan[i].repeats; k++) begin
					send_request(plan[i].mode, plan[i].glyph, plan[i].fixed_n,
						plan[i].fixed_cmd);
				end
			end
		end

		// Random part. Each block starts from an idle core with new register values;
		// a disabled block is kept short, as its characters are simply ignored.
		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					send_gap_pct   = 7;
					recv_stall_pct = 68;
				end
				1: begin
					send_gap_pct   = 68;
					recv_stall_pct = 7;
				end
				default: begin
					send_gap_pct   = 0;
					recv_stall_pct = 0;
				end
			endcase
			counted = 0;
			while (counted < PHASE_REQUESTS) begin
				wait_drained(SETTLE_CYCLES);
				write_register(REG_ENABLED, 32'($urandom_range(0, 5) != 0));
				write_register(REG_FG, $urandom_range(0, 15));
				write_register(REG_BG, $urandom_range(0, 15));
				block_len = en_reg ? BLOCK_REQUESTS : IGNORED_BLOCK;
				for (int k = 0; k < block_len; k++) begin
					// Now and then the sender holds back until the core has caught up.
					if ($urandom_range(0, 49) == 0) begin
						wait_drained(0);
					end
					pick_request(rq_mode, rq_glyph);
					send_request(rq_mode, rq_glyph, -1, no_cmd);
				end
				if (en_reg) begin
					counted += block_len;
				end
			end
		end

		wait_drained(SETTLE_CYCLES);
		if (failures == 0 && pending_cmds.size() == 0) begin
			$display("** text_console_cursor_engine_core: PASSED **");
		end else begin
			$display("** text_console_cursor_engine_core: FAILED **");
		end
		$finish;
	end

	// Watchdog: a hung handshake ends the run here.
	initial begin
		#(TIMEOUT_NS);
		$display("timeout with %0d commands still owed", pending_cmds.size());
		$display("** text_console_cursor_engine_core: FAILED **");
		$finish;
	end

endmodule

[sim.f]
design/tcce_pkg.sv
design/tcce_ifs.sv
design/tcce_ctrl.sv
design/tcce_dp.sv
design/text_console_cursor_engine_core.sv
bench/text_console_cursor_engine_core_test.sv
